[sv/stable_priority_queue_top_macros.svh]
// Assertion macros for the RTL, included by spq_queue.
`ifndef STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/spq_pkg.sv]
package spq_pkg;

  localparam int DefaultDepth = 16;
  localparam int EntryW       = 44;
  localparam int CountOutW    = 5;
  localparam int InDataW      = 48;
  localparam int OutDataW     = 56;
  localparam int InUserW      = 1;
  localparam int OutUserW     = 2;

  typedef enum logic {
    OpPush = 1'b0,
    OpPop  = 1'b1
  } op_e;

  // prio sits in the lowest bits
  typedef struct packed {
    logic [15:0] amount;
    logic [3:0]  status;
    logic [7:0]  resource;
    logic [7:0]  system;
    logic [7:0]  prio;
  } entry_t;

  typedef struct packed {
    logic push_en;
    logic pop_en;
  } shift_ctrl_t;

  typedef struct packed {
    logic                 push_dropped;
    logic                 pop_valid;
    logic [CountOutW-1:0] entry_count;
    entry_t               item;
  } result_t;

endpackage

[sv/spq_cell.sv]
module spq_cell
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  shift_ctrl_t ctrl_i,
  input  logic        valid_i,
  input  entry_t      new_entry_i,
  input  logic        prev_keep_i,
  input  entry_t      prev_entry_i,
  input  entry_t      next_entry_i,
  output logic        keep_o,
  output entry_t      entry_o
);

  entry_t entry_q, entry_d;

  // keep the slot when it stays ahead of the new item
  assign keep_o = valid_i && (entry_q.prio >= new_entry_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push_en) begin
      if (!keep_o) begin
        entry_d = prev_keep_i ? new_entry_i : prev_entry_i;
      end
    end else if (ctrl_i.pop_en) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[sv/spq_queue.sv]
module spq_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DefaultDepth,
  parameter int CntW  = $clog2(DEPTH + 1)
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    exec_i,
  input  op_e     op_i,
  input  entry_t  item_i,
  output result_t result_o
);

  `include "stable_priority_queue_top_macros.svh"

  logic [CntW-1:0] count_q, count_d;
  logic            full, empty;
  shift_ctrl_t     ctrl;
  logic            keep [DEPTH];
  entry_t          ent  [DEPTH];

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  assign ctrl.push_en = exec_i && (op_i == OpPush) && !full;
  assign ctrl.pop_en  = exec_i && (op_i == OpPop) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   prev_keep;
    entry_t prev_entry, next_entry;

    if (i == 0) begin : g_head
      assign prev_keep  = 1'b1;
      assign prev_entry = item_i;
    end else begin : g_body
      assign prev_keep  = keep[i-1];
      assign prev_entry = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = ent[i];
    end else begin : g_mid
      assign next_entry = ent[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (CntW'(i) < count_q),
      .new_entry_i  (item_i),
      .prev_keep_i  (prev_keep),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .keep_o       (keep[i]),
      .entry_o      (ent[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.push_en) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.pop_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign result_o.push_dropped = exec_i && (op_i == OpPush) && full;
  assign result_o.pop_valid    = ctrl.pop_en;
  assign result_o.entry_count  = CountOutW'(count_d);
  assign result_o.item         = ctrl.pop_en ? ent[0] : '0;

  `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CntW'(DEPTH), "count above depth")
  `SPQ_ASSERT_NXT(a_pop_dec, ctrl.pop_en, count_q == $past(count_q) - 1'b1,
                  "pop did not decrement count")
  `SPQ_ASSERT_NXT(a_push_inc, ctrl.push_en, count_q == $past(count_q) + 1'b1,
                  "push did not increment count")
  `SPQ_ASSERT_IMP(a_drop_full, result_o.push_dropped, full, "drop while not full")
  `SPQ_ASSERT_IMP(a_sorted, count_q >= CntW'(2), ent[0].prio >= ent[1].prio,
                  "head out of order")

endmodule

[sv/stable_priority_queue_top.sv]
// Stable priority queue of events.
// Slave channel s_axis: one item per handshake; tuser selects push (0) or pop (1),
// tdata carries the event for a push and is ignored for a pop.
// Master channel m_axis: exactly one item per accepted input item, in order.
// tuser flags a returned event (pop_valid) or a dropped push (push_dropped);
// tdata carries the popped event (zero otherwise) and the entry count after the op.
// Equal priorities leave in arrival order; a push to a full queue is dropped.
// Path: the input handshake loads the input register; when the output register is
// free or being read, the item moves through the compare-and-shift row of DEPTH
// cells into the result register.
// Throughput: one item per cycle while m_axis is not stalled, set by the parallel
// compare and shift over all cells.
// Stall: while m_axis is stalled one result waits in the output register and one
// item waits in the input register; s_axis_tready then drops until m_axis moves.
// Reset: rst_ni clears the entry count and both valid flags; the queue comes up
// empty with s_axis_tready high.
module stable_priority_queue_top
  import spq_pkg::*;
#(
  parameter int DEPTH = DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // in_priority[7:0], in_system[15:8], in_resource[23:16], in_status[27:24],
  // in_amount[43:28], zero [47:44]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // op[0]
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_priority[7:0], out_system[15:8], out_resource[23:16], out_status[27:24],
  // out_amount[43:28], entry_count[48:44], zero [55:49]
  output logic [OutDataW-1:0] m_axis_tdata,
  // pop_valid[0], push_dropped[1]
  output logic [OutUserW-1:0] m_axis_tuser
);

  logic    in_valid_q, in_valid_d;
  op_e     in_op_q;
  entry_t  in_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  result_t result;
  logic    advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign in_valid_d  = (s_axis_tvalid && s_axis_tready) || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= op_e'(s_axis_tuser[0]);
      in_item_q <= entry_t'(s_axis_tdata[EntryW-1:0]);
    end
    if (advance) begin
      out_q <= result;
    end
  end

  spq_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .exec_i   (advance),
    .op_i     (in_op_q),
    .item_i   (in_item_q),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - EntryW - CountOutW)'(0), out_q.entry_count,
                          out_q.item};
  assign m_axis_tuser  = {out_q.push_dropped, out_q.pop_valid};

endmodule

[sim/tb_stable_priority_queue_top.sv]
module tb_stable_priority_queue_top;
  import spq_pkg::*;

  localparam int QDEPTH    = DefaultDepth;
  localparam int RandItems = 1400;

  typedef struct {
    op_e         op;
    entry_t      ev;
    int unsigned gap;
    bit          drain;
  } stim_item_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  stim_item_t  op_stream[$];
  result_t     due_results[$];
  entry_t      shadow_store[QDEPTH];
  int unsigned shadow_count = 0;
  int unsigned issued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned err_cnt      = 0;
  int unsigned gap_left     = 0;
  int unsigned rx_stall     = 0;
  int unsigned rx_span      = 0;
  bit          rx_calm      = 1'b0;
  bit          tx_calm      = 1'b0;
  bit          in_taken     = 1'b0;

  stable_priority_queue_top #(
    .DEPTH(QDEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic entry_t make_event(logic [7:0] prio, logic [7:0] system,
                                        logic [7:0] resource, logic [3:0] status,
                                        logic [15:0] amount);
    entry_t ev;
    ev.prio     = prio;
    ev.system   = system;
    ev.resource = resource;
    ev.status   = status;
    ev.amount   = amount;
    return ev;
  endfunction

  function automatic entry_t rand_event(bit ties);
    entry_t      ev;
    int unsigned r;
    ev = EntryW'({$urandom(), $urandom()});
    r  = $urandom_range(0, 9);
    if (ties) begin
      r       = $urandom_range(0, 3);
      ev.prio = (r == 3) ? 8'hff : 8'(r);
    end else if (r == 0) begin
      ev.prio = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
    end
    return ev;
  endfunction

  task automatic add_item(input op_e op, input entry_t ev, input bit drain);
    stim_item_t it;
    it.op    = op;
    it.ev    = ev;
    it.gap   = tx_calm ? 0 : pick_gap();
    it.drain = drain;
    op_stream.push_back(it);
    issued_cnt++;
  endtask

  // insert behind all entries of greater or equal priority; pop from the head
  function automatic result_t apply_queue_op(op_e op, entry_t ev);
    result_t     r;
    int unsigned pos;
    r = '0;
    if (op == OpPush) begin
      if (shadow_count >= QDEPTH) begin
        r.push_dropped = 1'b1;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_store[pos].prio >= ev.prio) pos++;
        for (int unsigned i = shadow_count; i > pos; i--) shadow_store[i] = shadow_store[i-1];
        shadow_store[pos] = ev;
        shadow_count++;
      end
    end else if (shadow_count != 0) begin
      r.pop_valid = 1'b1;
      r.item      = shadow_store[0];
      for (int unsigned i = 1; i < shadow_count; i++) shadow_store[i-1] = shadow_store[i];
      shadow_count--;
    end
    r.entry_count = CountOutW'(shadow_count);
    return r;
  endfunction

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      err_cnt++;
    end
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      in_taken      = 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (op_stream.size() != 0 &&
                   (!op_stream[0].drain || due_results.size() == 0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op_stream[0].op;
        s_axis_tdata  <= InDataW'(op_stream[0].ev);
        void'(op_stream.pop_front());
        gap_left = (op_stream.size() != 0) ? op_stream[0].gap : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_span == 0) begin
      rx_calm = ($urandom_range(0, 2) == 0);
      rx_span = $urandom_range(20, 200);
    end else begin
      rx_span--;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_calm) rx_stall = pick_gap();
    end
  end

  always @(posedge clk_i) begin : monitor
    result_t want;
    entry_t  got_ev;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $error("result item with no operation pending");
          err_cnt++;
        end else begin
          want   = due_results.pop_front();
          got_ev = entry_t'(m_axis_tdata[EntryW-1:0]);
          check_field("pop_valid", want.pop_valid, m_axis_tuser[0]);
          check_field("push_dropped", want.push_dropped, m_axis_tuser[1]);
          check_field("out_priority", want.item.prio, got_ev.prio);
          check_field("out_system", want.item.system, got_ev.system);
          check_field("out_resource", want.item.resource, got_ev.resource);
          check_field("out_status", want.item.status, got_ev.status);
          check_field("out_amount", want.item.amount, got_ev.amount);
          check_field("entry_count", want.entry_count,
                      m_axis_tdata[EntryW +: CountOutW]);
          check_field("tdata_pad", 0, m_axis_tdata[OutDataW-1:EntryW+CountOutW]);
        end
      end
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        due_results.push_back(apply_queue_op(op_e'(s_axis_tuser[0]),
                                             entry_t'(s_axis_tdata[EntryW-1:0])));
        accepted_cnt++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned phase_len;
    int unsigned push_pct;
    bit          ties;

    add_item(OpPop,  entry_t'('1), 1'b0);
    add_item(OpPush, entry_t'('0), 1'b0);
    add_item(OpPush, entry_t'('1), 1'b0);
    add_item(OpPush, make_event(8'hff, 8'h01, 8'h02, 4'h3, 16'h0004), 1'b0);
    add_item(OpPush, make_event(8'h00, 8'h11, 8'h22, 4'h5, 16'h8000), 1'b0);
    add_item(OpPush, make_event(8'h80, 8'haa, 8'h55, 4'ha, 16'h5555), 1'b0);
    add_item(OpPush, make_event(8'h80, 8'h55, 8'haa, 4'h5, 16'haaaa), 1'b0);
    repeat (6) add_item(OpPop, entry_t'('0), 1'b0);
    add_item(OpPop,  rand_event(1'b0), 1'b0);
    add_item(OpPush, make_event(8'h07, 8'h01, 8'h01, 4'h1, 16'h0001), 1'b0);
    add_item(OpPush, make_event(8'h09, 8'h02, 8'h02, 4'h2, 16'h0002), 1'b0);
    add_item(OpPush, make_event(8'h07, 8'h03, 8'h03, 4'h3, 16'h0003), 1'b0);
    add_item(OpPush, make_event(8'hc8, 8'h04, 8'h04, 4'h4, 16'h0004), 1'b0);
    repeat (5) add_item(OpPop, rand_event(1'b0), 1'b0);

    while (issued_cnt < RandItems) begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(0, 4))
        0: push_pct = 90;
        1: push_pct = 15;
        2: push_pct = 50;
        3: push_pct = 70;
        default: push_pct = 30;
      endcase
      ties    = ($urandom_range(0, 2) == 0);
      tx_calm = ($urandom_range(0, 3) == 0);
      for (int unsigned k = 0; k < phase_len; k++) begin
        add_item(($urandom_range(0, 99) < push_pct) ? OpPush : OpPop, rand_event(ties),
                 k == 0 && (issued_cnt < 40 || $urandom_range(0, 3) == 0));
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_cnt != issued_cnt) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[stable_priority_queue_top.f]
+incdir+sv
sv/spq_pkg.sv
sv/spq_cell.sv
sv/spq_queue.sv
sv/stable_priority_queue_top.sv
sim/tb_stable_priority_queue_top.sv
